/* sv/slcd_pkg.sv */
// types and constants shared by the serial display command decoder
// no dependencies

package slcd_pkg;

   localparam int BYTE_W = 8;
   localparam int OP_W = 2;
   localparam int ROW_W = 3;
   localparam int LINE_W = 8;
   localparam int ROWS_W = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_CURSOR = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

   localparam logic [BYTE_W-1:0] CMD_CLS = 8'h00;
   localparam logic [BYTE_W-1:0] CMD_RAW = 8'h01;
   localparam logic [BYTE_W-1:0] CMD_PAGE = 8'h02;

   localparam logic [CSR_INDEX_W-1:0] CSR_CHARS_PER_LINE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_ON_DISPLAY = 1'd1;

   localparam logic [LINE_W-1:0] CHARS_PER_LINE_RESET = 8'd20;
   localparam logic [ROWS_W-1:0] ROWS_ON_DISPLAY_RESET = 4'd4;
   localparam logic [ROW_W-1:0] LAST_ROW = 3'd7;

   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_CURSOR = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;
   localparam logic [1:0] KIND_CURSOR_WRITE = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [ROW_W-1:0] row;
      logic [BYTE_W-1:0] char_code;
   } entry_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [ROW_W-1:0] row;
      logic [BYTE_W-1:0] char_code;
      logic last;
   } result_type;

endpackage

/* sv/slcd_req_if.sv */
// request channel: one received serial word
// depends on slcd_pkg

interface slcd_req_if;
   logic valid;
   logic ready;
   logic [slcd_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

/* sv/slcd_rsp_if.sv */
// response channel: one display operation word
// depends on slcd_pkg

interface slcd_rsp_if;
   logic valid;
   logic ready;
   logic [slcd_pkg::OP_W-1:0] op;
   logic [slcd_pkg::ROW_W-1:0] row;
   logic [slcd_pkg::BYTE_W-1:0] char_code;
   logic last;

   modport source (output valid, output op, output row, output char_code, output last,
                   input ready);
   modport sink (input valid, input op, input row, input char_code, input last,
                 output ready);
endinterface

/* sv/slcd_front.sv */
// front end: accepts serial words, tracks command mode and page position,
// and pushes display work entries; holds the configuration registers; uses slcd_pkg

module slcd_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [slcd_pkg::BYTE_W-1:0] in_byte,
   input  logic csr_we,
   input  logic [slcd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [slcd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic push,
   output slcd_pkg::entry_type push_entry,
   input  logic queue_full
);
   import slcd_pkg::*;

   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_RAW_LEN = 3'd1;
   localparam logic [2:0] M_RAW_CHARS = 3'd2;
   localparam logic [2:0] M_PAGE_LEN = 3'd3;
   localparam logic [2:0] M_PAGE_CHARS = 3'd4;

   logic [2:0] mode_ff, mode_in;
   logic [BYTE_W-1:0] left_ff, left_in;
   logic [LINE_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic started_ff, started_in;
   logic [LINE_W-1:0] cpl_ff;
   logic [ROWS_W-1:0] rows_ff;
   logic take;
   logic [BYTE_W-1:0] left_dec;
   logic [LINE_W:0] col_next;
   logic [ROWS_W-1:0] row_next;

   assign in_ready = !queue_full;
   assign take = in_valid && in_ready;
   assign left_dec = left_ff - 1'b1;
   assign col_next = {1'b0, col_ff} + 1'b1;
   assign row_next = {1'b0, row_ff} + 1'b1;

   always_comb begin
      mode_in = mode_ff;
      left_in = left_ff;
      col_in = col_ff;
      row_in = row_ff;
      started_in = started_ff;
      push = 1'b0;
      push_entry = '0;
      if (take) begin
         case (mode_ff)
            M_IDLE: begin
               if (in_byte == CMD_CLS) begin
                  push = 1'b1;
                  push_entry.kind = KIND_CLEAR;
               end else if (in_byte == CMD_RAW) begin
                  mode_in = M_RAW_LEN;
               end else if (in_byte == CMD_PAGE) begin
                  push = 1'b1;
                  push_entry.kind = KIND_CURSOR;
                  mode_in = M_PAGE_LEN;
               end
            end
            M_RAW_LEN: begin
               left_in = in_byte;
               mode_in = (in_byte == '0) ? M_IDLE : M_RAW_CHARS;
            end
            M_RAW_CHARS: begin
               push = 1'b1;
               push_entry.kind = KIND_WRITE;
               push_entry.char_code = in_byte;
               left_in = left_dec;
               if (left_dec == '0) begin
                  mode_in = M_IDLE;
               end
            end
            M_PAGE_LEN: begin
               left_in = in_byte;
               col_in = '0;
               row_in = '0;
               started_in = 1'b0;
               mode_in = (in_byte == '0) ? M_IDLE : M_PAGE_CHARS;
            end
            M_PAGE_CHARS: begin
               push = 1'b1;
               push_entry.char_code = in_byte;
               if (col_ff == '0) begin
                  push_entry.kind = KIND_CURSOR_WRITE;
                  started_in = 1'b1;
                  if (!started_ff || row_next >= rows_ff || row_ff == LAST_ROW) begin
                     row_in = '0;
                  end else begin
                     row_in = row_next[ROW_W-1:0];
                  end
                  push_entry.row = row_in;
               end else begin
                  push_entry.kind = KIND_WRITE;
               end
               if (cpl_ff != '0 && col_next >= {1'b0, cpl_ff}) begin
                  col_in = '0;
               end else begin
                  col_in = col_next[LINE_W-1:0];
               end
               left_in = left_dec;
               if (left_dec == '0) begin
                  mode_in = M_IDLE;
               end
            end
            default: begin
               mode_in = M_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         left_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
         started_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         left_ff <= left_in;
         col_ff <= col_in;
         row_ff <= row_in;
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpl_ff <= CHARS_PER_LINE_RESET;
         rows_ff <= ROWS_ON_DISPLAY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CHARS_PER_LINE: cpl_ff <= csr_wdata[LINE_W-1:0];
            CSR_ROWS_ON_DISPLAY: rows_ff <= csr_wdata[ROWS_W-1:0];
            default: ;
         endcase
      end
   end
endmodule

/* sv/slcd_queue.sv */
// short first-in first-out queue of work entries between front and back
// uses slcd_pkg

module slcd_queue #(
   parameter int DEPTH = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  slcd_pkg::entry_type push_entry,
   output logic full,
   input  logic pop,
   output logic not_empty,
   output slcd_pkg::entry_type head
);
   import slcd_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   entry_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] count_ff;
   logic do_push, do_pop;

   assign full = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head = slot_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop = pop && not_empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == LAST_SLOT) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == LAST_SLOT) ? '0 : rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end
endmodule

/* sv/slcd_back.sv */
// back end: takes work entries and drives the registered response word,
// splitting a cursor-then-write entry into two words; uses slcd_pkg

module slcd_back (
   input  logic clock,
   input  logic reset,
   input  logic entry_valid,
   input  slcd_pkg::entry_type entry,
   output logic pop,
   output logic out_valid,
   input  logic out_ready,
   output slcd_pkg::result_type out_word
);
   import slcd_pkg::*;

   logic valid_ff;
   result_type word_ff, word_in;
   logic pend_ff;
   logic [BYTE_W-1:0] pend_char_ff;
   logic load;

   assign load = !valid_ff || out_ready;
   assign pop = load && !pend_ff && entry_valid;
   assign out_valid = valid_ff;
   assign out_word = word_ff;

   always_comb begin
      word_in = '0;
      word_in.last = 1'b1;
      if (pend_ff) begin
         word_in.op = OP_WRITE;
         word_in.char_code = pend_char_ff;
      end else begin
         case (entry.kind)
            KIND_CLEAR: word_in.op = OP_CLEAR;
            KIND_CURSOR: begin
               word_in.op = OP_CURSOR;
               word_in.row = entry.row;
            end
            KIND_WRITE: begin
               word_in.op = OP_WRITE;
               word_in.char_code = entry.char_code;
            end
            KIND_CURSOR_WRITE: begin
               word_in.op = OP_CURSOR;
               word_in.row = entry.row;
               word_in.last = 1'b0;
            end
            default: word_in.op = OP_CLEAR;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= pend_ff || entry_valid;
         if (pend_ff) begin
            pend_ff <= 1'b0;
         end else if (entry_valid && entry.kind == KIND_CURSOR_WRITE) begin
            pend_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
         if (!pend_ff) begin
            pend_char_ff <= entry.char_code;
         end
      end
   end
endmodule

/* sv/serial_lcd_command_decoder.sv */
// serial display command decoder: a word is taken each cycle while the queue has room;
// any work entry it makes passes through the queue, then the response register, which
// gives one word a cycle while not stalled; a cursor-then-write entry gives two words
// synchronous active-high reset clears mode, page position, queue and response valid,
// and sets the line width to 20 and the row count to 4
// depends on slcd_pkg, slcd_req_if, slcd_rsp_if, slcd_front, slcd_queue, slcd_back

module serial_lcd_command_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic clock,
   input  logic reset,
   slcd_req_if.sink req_chan,
   slcd_rsp_if.source rsp_chan,
   input  logic csr_we,
   input  logic [slcd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [slcd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import slcd_pkg::*;

   logic push, full, pop, not_empty;
   entry_type push_entry, head;
   result_type word;

   slcd_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_chan.valid), .in_ready(req_chan.ready), .in_byte(req_chan.rx_byte),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .push(push), .push_entry(push_entry), .queue_full(full)
   );

   slcd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_entry(push_entry), .full(full),
      .pop(pop), .not_empty(not_empty), .head(head)
   );

   slcd_back u_back (
      .clock(clock), .reset(reset),
      .entry_valid(not_empty), .entry(head), .pop(pop),
      .out_valid(rsp_chan.valid), .out_ready(rsp_chan.ready), .out_word(word)
   );

   assign rsp_chan.op = word.op;
   assign rsp_chan.row = word.row;
   assign rsp_chan.char_code = word.char_code;
   assign rsp_chan.last = word.last;
endmodule

/* sv/slcd_checker.sv */
// port-level checks on the decoder's response channel, bound to the top level
// uses slcd_pkg

module slcd_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [slcd_pkg::OP_W-1:0] rsp_op,
   input logic [slcd_pkg::ROW_W-1:0] rsp_row,
   input logic [slcd_pkg::BYTE_W-1:0] rsp_char_code,
   input logic rsp_last
);
   import slcd_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_op) && $stable(rsp_row)
         && $stable(rsp_char_code) && $stable(rsp_last))
      else $error("stalled response word changed");

   a_split: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_op == OP_CURSOR && !rsp_last
         |=> rsp_valid && rsp_op == OP_WRITE && rsp_last)
      else $error("row cursor move not followed by its write");

   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_op == OP_CLEAR || rsp_op == OP_CURSOR || rsp_op == OP_WRITE)
         && (rsp_op == OP_CURSOR || rsp_row == '0)
         && (rsp_op == OP_WRITE || rsp_char_code == '0))
      else $error("response fields inconsistent with operation");

   a_lone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_op == OP_CURSOR)
      else $error("only a cursor move may lead a two-word result");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
endmodule

bind serial_lcd_command_decoder slcd_checker u_slcd_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
   .rsp_op(rsp_chan.op), .rsp_row(rsp_chan.row),
   .rsp_char_code(rsp_chan.char_code), .rsp_last(rsp_chan.last)
);
